[rtl/ttrs_pkg.sv]
// Package for the tick task release scheduler.
// Holds the item structs, status codes, controller states and the
// command and status structs between controller and datapath. No dependencies.
`timescale 1ns / 1ps

package ttrs_pkg;

	// Field widths fixed by the item format.
	localparam int SLOT_W    = 4;
	localparam int VAL_W     = 32;
	localparam int TICK_W    = 64;
	localparam int MASK_W    = 8;
	localparam int STATUS_W  = 2;
	localparam int SLOTS_DEF = 8;

	// Status codes of a result item.
	localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_TAKEN = 2'd2;

	// Item modes.
	localparam logic MODE_TICK = 1'b0;
	localparam logic MODE_REG  = 1'b1;

	typedef struct packed {
		logic              mode;
		logic [SLOT_W-1:0] slot;
		logic [VAL_W-1:0]  first_delay;
		logic [VAL_W-1:0]  period;
	} req_item_t;

	typedef struct packed {
		logic [MASK_W-1:0]   fire_mask;
		logic [STATUS_W-1:0] status;
	} rsp_item_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_DIV
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic latch;
		logic do_tick;
		logic do_reject;
		logic div_start;
		logic do_commit;
	} dp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic mode;
		logic reg_ok;
		logic div_busy;
	} dp_stat_t;

endpackage

[rtl/tick_task_release_scheduler_core.sv]
// Top level of the tick task release scheduler.
// Depends on ttrs_pkg, ttrs_ctrl, ttrs_datapath and ttrs_mod_unit.
//
// Usage:
// Items enter on the req channel (req_valid, req_stall, req) and each one
// gives exactly one result on the rsp channel (rsp_valid, rsp_stall, rsp).
// A tick item returns the mask of slots that fire on the current tick count
// and then advances the count. A register item claims a free slot and
// returns a status: ok, slot out of range, or slot already taken.
// Items are handled one at a time. A tick item or a rejected registration
// loads its result in the execute step, and a new item is accepted only
// once that item has left that step. A successful registration goes on to
// a division step and loads its result once both remainder units are done:
// the phases of the tick count against the delay and the period come
// from two bit-serial remainder units that take one tick count bit per
// cycle. Ticks themselves need no division: every slot keeps phase
// counters that step with each tick.
// Reset clears the tick count and frees all slots at once.
// The result register lets the next item be accepted while a result waits;
// while rsp_stall holds a waiting result, a finished item waits in its execute
// or division step and no further item is accepted.
`timescale 1ns / 1ps

module tick_task_release_scheduler_core #(
	parameter int SLOTS = ttrs_pkg::SLOTS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_stall,
	input  ttrs_pkg::req_item_t req,
	output logic                rsp_valid,
	input  logic                rsp_stall,
	output ttrs_pkg::rsp_item_t rsp
);
	import ttrs_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;

	// Item sequencing.
	ttrs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	// Slot table and arithmetic.
	ttrs_datapath #(
		.SLOTS (SLOTS)
	) u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.cmd    (cmd),
		.stat   (stat),
		.rsp    (rsp)
	);

endmodule

[rtl/ttrs_mod_unit.sv]
// Bit-serial remainder unit: tick count modulo a 32-bit divisor.
// Restoring division, one dividend bit per cycle. Depends on ttrs_pkg.
`timescale 1ns / 1ps

module ttrs_mod_unit (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [ttrs_pkg::TICK_W-1:0] dividend,
	input  logic [ttrs_pkg::VAL_W-1:0]  divisor,
	output logic                       busy,
	output logic [ttrs_pkg::VAL_W-1:0]  rem
);
	import ttrs_pkg::*;

	localparam int CNT_W = $clog2(TICK_W);

	logic              busy_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [TICK_W-1:0] num_q;
	logic [VAL_W-1:0]  rem_q;
	logic [VAL_W-1:0]  dsr_q;
	logic [VAL_W:0]    trial;
	logic [VAL_W:0]    rem_next;

	// One restoring step: shift in the next bit, subtract when it fits.
	always_comb begin
		trial = {rem_q, num_q[TICK_W-1]};
		if (trial >= {1'b0, dsr_q}) begin
			rem_next = trial - {1'b0, dsr_q};
		end else begin
			rem_next = trial;
		end
	end

	// Step counter and busy flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CNT_W'(TICK_W - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	// Dividend shift register and partial remainder.
	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (busy_q) begin
			num_q <= {num_q[TICK_W-2:0], 1'b0};
			rem_q <= rem_next[VAL_W-1:0];
		end
	end

	assign busy = busy_q;
	assign rem  = rem_q;

endmodule

[rtl/ttrs_ctrl.sv]
// Controller of the scheduler: sequences one item at a time and owns
// the input stall and the result valid flag. Depends on ttrs_pkg.
`timescale 1ns / 1ps

module ttrs_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_stall,
	output logic               rsp_valid,
	input  logic               rsp_stall,
	input  ttrs_pkg::dp_stat_t stat,
	output ttrs_pkg::dp_cmd_t  cmd
);
	import ttrs_pkg::*;

	state_t state_q;
	state_t state_d;
	logic   rsp_valid_q;
	logic   out_free;
	logic   out_load;

	// The result register can take a new item when empty or being drained.
	assign out_free = !rsp_valid_q || !rsp_stall;
	assign out_load = cmd.do_tick || cmd.do_reject || cmd.do_commit;

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (stat.mode == MODE_REG && stat.reg_ok) begin
					state_d = ST_DIV;
				end else if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			ST_DIV: begin
				if (!stat.div_busy && out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Outputs per state.
	always_comb begin
		cmd       = '0;
		req_stall = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				req_stall = 1'b0;
				cmd.latch = req_valid;
			end
			ST_EXEC: begin
				if (stat.mode == MODE_TICK) begin
					cmd.do_tick = out_free;
				end else if (!stat.reg_ok) begin
					cmd.do_reject = out_free;
				end else begin
					cmd.div_start = 1'b1;
				end
			end
			ST_DIV: begin
				cmd.do_commit = !stat.div_busy && out_free;
			end
			default: begin
				req_stall = 1'b1;
			end
		endcase
	end

	// State and result valid registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign rsp_valid = rsp_valid_q;

endmodule

[rtl/ttrs_datapath.sv]
// Datapath of the scheduler: slot table, tick counter, per-slot phase
// counters, two remainder units and the result register.
// Depends on ttrs_pkg and ttrs_mod_unit.
`timescale 1ns / 1ps

module ttrs_datapath #(
	parameter int SLOTS = ttrs_pkg::SLOTS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  ttrs_pkg::req_item_t req,
	input  ttrs_pkg::dp_cmd_t   cmd,
	output ttrs_pkg::dp_stat_t  stat,
	output ttrs_pkg::rsp_item_t rsp
);
	import ttrs_pkg::*;

	req_item_t         item_q;
	rsp_item_t         rsp_q;
	logic [TICK_W-1:0] tick_q;

	logic [SLOTS-1:0] used_q;
	logic [SLOTS-1:0] pending_q;
	logic [VAL_W-1:0] dval_q [SLOTS];
	logic [VAL_W-1:0] pval_q [SLOTS];
	logic [VAL_W-1:0] dph_q  [SLOTS];
	logic [VAL_W-1:0] pph_q  [SLOTS];

	logic [SLOTS-1:0]  slot_hit;
	logic [SLOTS-1:0]  fire;
	logic [SLOTS-1:0]  delay_fire;
	logic [VAL_W-1:0]  dph_next [SLOTS];
	logic [VAL_W-1:0]  pph_next [SLOTS];
	logic [MASK_W-1:0] mask;
	logic              in_range;
	logic              taken;
	logic              tick_last;
	logic              dbusy;
	logic              pbusy;
	logic [VAL_W-1:0]  drem;
	logic [VAL_W-1:0]  prem;

	// Phases of the stored tick count against the new delay and period.
	ttrs_mod_unit u_mod_delay (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (tick_q),
		.divisor  (item_q.first_delay),
		.busy     (dbusy),
		.rem      (drem)
	);

	ttrs_mod_unit u_mod_period (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (tick_q),
		.divisor  (item_q.period),
		.busy     (pbusy),
		.rem      (prem)
	);

	assign tick_last = &tick_q;
	assign in_range  = {1'b0, item_q.slot} < (SLOT_W + 1)'(SLOTS);

	// Slot decode, occupancy check and the fire decision of every slot.
	always_comb begin
		logic [VAL_W:0] dinc;
		logic [VAL_W:0] pinc;
		mask  = '0;
		taken = 1'b0;
		for (int i = 0; i < SLOTS; i++) begin
			slot_hit[i]   = item_q.slot == SLOT_W'(i);
			taken         = taken | (slot_hit[i] & used_q[i]);
			delay_fire[i] = used_q[i] && pending_q[i] && (tick_q != '0) && (dph_q[i] == '0);
			fire[i]       = delay_fire[i] ||
				(used_q[i] && !pending_q[i] && (pval_q[i] != '0) && (pph_q[i] == '0));
			if (i < MASK_W) begin
				mask[i] = fire[i];
			end
			// Phase advance: wrap at the divisor, and to zero with the tick count.
			dinc = {1'b0, dph_q[i]} + 1'b1;
			pinc = {1'b0, pph_q[i]} + 1'b1;
			if (tick_last || dinc == {1'b0, dval_q[i]}) begin
				dph_next[i] = '0;
			end else begin
				dph_next[i] = dinc[VAL_W-1:0];
			end
			if (tick_last || pinc == {1'b0, pval_q[i]}) begin
				pph_next[i] = '0;
			end else begin
				pph_next[i] = pinc[VAL_W-1:0];
			end
		end
	end

	// Control flags of the slot table and the tick counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q    <= '0;
			pending_q <= '0;
			tick_q    <= '0;
		end else if (cmd.do_tick) begin
			pending_q <= pending_q & ~delay_fire;
			tick_q    <= tick_q + 1'b1;
		end else if (cmd.do_commit) begin
			for (int i = 0; i < SLOTS; i++) begin
				if (slot_hit[i]) begin
					used_q[i]    <= 1'b1;
					pending_q[i] <= item_q.first_delay != '0;
				end
			end
		end
	end

	// Stored values and phase counters of every slot.
	always_ff @(posedge clk) begin
		for (int i = 0; i < SLOTS; i++) begin
			if (cmd.do_tick) begin
				dph_q[i] <= dph_next[i];
				pph_q[i] <= pph_next[i];
			end else if (cmd.do_commit && slot_hit[i]) begin
				dval_q[i] <= item_q.first_delay;
				pval_q[i] <= item_q.period;
				dph_q[i]  <= drem;
				pph_q[i]  <= prem;
			end
		end
	end

	// Input item capture and result register.
	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			item_q <= req;
		end
		if (cmd.do_tick) begin
			rsp_q.fire_mask <= mask;
			rsp_q.status    <= STATUS_OK;
		end else if (cmd.do_reject) begin
			rsp_q.fire_mask <= '0;
			rsp_q.status    <= in_range ? STATUS_TAKEN : STATUS_RANGE;
		end else if (cmd.do_commit) begin
			rsp_q.fire_mask <= '0;
			rsp_q.status    <= STATUS_OK;
		end
	end

	assign stat.mode     = item_q.mode;
	assign stat.reg_ok   = in_range && !taken;
	assign stat.div_busy = dbusy || pbusy;
	assign rsp           = rsp_q;

endmodule
